>>> rtl/imd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IMD deframer package
// Shared types, codes and constants of the IMD image deframer.
// ----------------------------------------------------------------------------
package imd_pkg;

  localparam int unsigned MaxSectorsDef      = 256;
  localparam int unsigned MaxTrackRecordsDef = 204;
  localparam logic [7:0]  TrackLimitReset    = 8'd164;
  localparam logic [7:0]  CommentEnd         = 8'h1a;

  typedef enum logic [3:0] {
    PH_SIG, PH_CMT_FIRST, PH_CMT_NEXT, PH_HDR, PH_SMAP, PH_CMAP, PH_HMAP,
    PH_SREC, PH_FILL, PH_DATA, PH_DONE, PH_ERR
  } phase_e;

  typedef enum logic [2:0] {
    KIND_FILL = 3'd0, KIND_HEADER = 3'd1, KIND_DATA = 3'd2, KIND_ERROR = 3'd3,
    KIND_DONE = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0, ERR_NOT_IMD = 3'd1, ERR_MODE = 3'd2, ERR_HEAD = 3'd3,
    ERR_SIZE = 3'd4, ERR_TOO_LARGE = 3'd5, ERR_TRUNCATED = 3'd6,
    ERR_TOO_MANY = 3'd7
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] cylinder;
    logic [7:0] head;
    logic [7:0] sector_id;
    logic [2:0] size_code;
    logic       deleted;
    logic       fm_track;
    logic [7:0] value;
    logic       last_byte;
    logic [2:0] error_code;
  } out_item_t;

  // map write and read request from the parser to the map store
  typedef struct packed {
    logic       we_s;
    logic       we_c;
    logic       we_h;
    logic [7:0] idx;
    logic [7:0] wdata;
    logic       re;
    logic [7:0] ridx;
  } map_req_t;

  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] cyl;
    logic [7:0] hd;
  } map_rd_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = 8'h49;
      3'd1: r = 8'h4d;
      3'd2: r = 8'h44;
      3'd3: r = 8'h20;
      3'd4: r = 8'h31;
      3'd5: r = 8'h2e;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/imd_disk_image_deframer.sv
`default_nettype none
// An accepted item's result is held in the output register from the next cycle on.
// Throughput: one item per cycle while no result waits; the map store is read one
// sector ahead so the sector ID is ready when the sector record byte arrives.
// A waiting result holds off the input; it may leave as the next item enters.
// Reset: asynchronous, active low; parser returns to signature check,
// maps are not cleared (only entries written in the current track are read).
// ----------------------------------------------------------------------------
// IMD disk image deframer
// Byte-wise IMD parser with map memories and a registered result stage.
// ----------------------------------------------------------------------------
module imd_disk_image_deframer #(
  parameter int unsigned MaxSectors      = imd_pkg::MaxSectorsDef,
  parameter int unsigned MaxTrackRecords = imd_pkg::MaxTrackRecordsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire imd_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output imd_pkg::out_item_t      out_data_o
);
  import imd_pkg::*;

  localparam logic [7:0] TrackCap = 8'(MaxTrackRecords);

  logic [7:0]  limit_q;
  phase_e      ph_q, ph_d;
  logic [7:0]  fc_q, fc_d;
  logic [2:0]  mode_q, mode_d;
  logic [7:0]  cyl_q, cyl_d;
  logic [7:0]  hf_q, hf_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [2:0]  size_q, size_d;
  logic [13:0] left_q, left_d;
  logic [7:0]  seen_q, seen_d;
  logic        ov_q;
  out_item_t   od_q;
  logic        emit;
  out_item_t   res;
  map_req_t    mreq;
  map_rd_t     mrd;
  logic        acc;
  logic [7:0]  b;
  logic        eof;
  logic [7:0]  fc_inc;
  logic [22:0] total;

  imd_map_store #(.MaxSectors(MaxSectors)) u_maps (
    .clk_i (clk_i),
    .req_i (mreq),
    .rd_o  (mrd)
  );

  assign in_ready_o  = !ov_q || out_ready_i;
  assign acc         = in_valid_i && in_ready_o;
  assign b           = in_data_i.data_byte;
  assign eof         = in_data_i.stream_end;
  assign fc_inc      = fc_q + 8'd1;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign total       = 23'({15'd0, cnt_q} << (7 + 32'(size_q)));

  // map store access: writes in the map phases; read address follows fc_d
  always_comb begin
    mreq       = '0;
    mreq.idx   = fc_q;
    mreq.wdata = b;
    mreq.ridx  = fc_d;
    mreq.re    = acc;
    if (acc && !eof) begin
      mreq.we_s = (ph_q == PH_SMAP);
      mreq.we_c = (ph_q == PH_CMAP);
      mreq.we_h = (ph_q == PH_HMAP);
    end
  end

  function automatic out_item_t sector_res(input logic [2:0] k, input logic del,
                                           input logic [7:0] v, input map_rd_t m,
                                           input logic [7:0] hf, input logic [7:0] cy,
                                           input logic [2:0] sz, input logic [2:0] md);
    out_item_t r;
    r                = '0;
    r.kind           = k;
    r.cylinder       = hf[7] ? m.cyl : cy;
    r.head           = hf[6] ? m.hd : {4'd0, hf[3:0]};
    r.sector_id      = m.sec;
    r.size_code      = sz;
    r.deleted        = del;
    r.fm_track       = (md <= 3'd2);
    r.value          = v;
    return r;
  endfunction

  always_comb begin
    ph_d   = ph_q;
    fc_d   = fc_q;
    mode_d = mode_q;
    cyl_d  = cyl_q;
    hf_d   = hf_q;
    cnt_d  = cnt_q;
    size_d = size_q;
    left_d = left_q;
    seen_d = seen_q;
    emit   = 1'b0;
    res    = '0;
    if (acc) begin
      case (ph_q)
        PH_SIG: begin
          if (eof || fc_q >= 8'd6 || b != sig_byte(fc_q[2:0])) begin
            ph_d = PH_ERR; emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_NOT_IMD;
          end else if (fc_inc == 8'd6) begin
            ph_d = PH_CMT_FIRST; fc_d = '0;
          end else begin
            fc_d = fc_inc;
          end
        end
        PH_CMT_FIRST, PH_CMT_NEXT: begin
          if (eof) begin
            emit = 1'b1;
            if (ph_q == PH_CMT_FIRST) begin
              ph_d = PH_ERR; res.kind = KIND_ERROR; res.error_code = ERR_NOT_IMD;
            end else begin
              ph_d = PH_DONE; res.kind = KIND_DONE;
            end
          end else if (b == CommentEnd) begin
            ph_d = PH_HDR; fc_d = '0; seen_d = '0;
          end
        end
        PH_HDR: begin
          if (fc_q == 8'd0 && seen_q >= limit_q) begin
            ph_d = PH_ERR; emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_TOO_MANY;
          end else if (fc_q == 8'd0 && seen_q >= TrackCap) begin
            if (eof) begin
              ph_d = PH_DONE; emit = 1'b1; res.kind = KIND_DONE;
            end else if (b == CommentEnd) begin
              seen_d = '0;
            end else begin
              ph_d = PH_CMT_NEXT;
            end
          end else if (eof) begin
            ph_d = PH_DONE; emit = 1'b1; res.kind = KIND_DONE;
          end else begin
            case (fc_q)
              8'd0:    mode_d = (b > 8'd5) ? 3'd7 : b[2:0];
              8'd1:    cyl_d  = b;
              8'd2:    hf_d   = b;
              8'd3:    cnt_d  = b;
              default: size_d = (b > 8'd6) ? 3'd7 : b[2:0];
            endcase
            if (fc_q < 8'd4) begin
              fc_d = fc_inc;
            end else begin
              fc_d = '0;
              if (mode_q > 3'd5) begin
                ph_d = PH_ERR; emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_MODE;
              end else if (hf_q[3:0] > 4'd1) begin
                ph_d = PH_ERR; emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_HEAD;
              end else if (b > 8'd6) begin
                ph_d = PH_ERR; emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_SIZE;
              end else if (cnt_q == 8'd0) begin
                ph_d = PH_HDR; seen_d = seen_q + 8'd1;
              end else begin
                ph_d = PH_SMAP;
              end
            end
          end
        end
        PH_SMAP, PH_CMAP, PH_HMAP: begin
          if (eof) begin
            ph_d = PH_ERR; emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_TRUNCATED;
          end else if (fc_inc != cnt_q) begin
            fc_d = fc_inc;
          end else begin
            fc_d = '0;
            if (ph_q == PH_SMAP && hf_q[7]) begin
              ph_d = PH_CMAP;
            end else if (ph_q != PH_HMAP && hf_q[6]) begin
              ph_d = PH_HMAP;
            end else if (total > 23'd32768) begin
              ph_d = PH_ERR; emit = 1'b1; res.kind = KIND_ERROR;
              res.error_code = ERR_TOO_LARGE;
            end else begin
              ph_d = PH_SREC;
            end
          end
        end
        PH_SREC: begin
          if (eof) begin
            ph_d = PH_ERR; emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_TRUNCATED;
          end else if (b == 8'd0) begin
            emit = 1'b1;
            res  = sector_res(KIND_FILL, 1'b0, 8'd0, mrd, hf_q, cyl_q, size_q, mode_q);
            if (fc_inc == cnt_q) begin
              ph_d = PH_HDR; fc_d = '0; seen_d = seen_q + 8'd1;
            end else begin
              fc_d = fc_inc;
            end
          end else if (b[0] == 1'b0) begin
            // type-1 odd: compressed
            left_d = {13'd0, ~b[1]};
            ph_d   = PH_FILL;
          end else begin
            // type-1 even: bit 1 of type-1 equals bit 1 of type
            emit   = 1'b1;
            res    = sector_res(KIND_HEADER, b[1], 8'd0, mrd, hf_q, cyl_q, size_q, mode_q);
            left_d = 14'(15'd128 << size_q);
            ph_d   = PH_DATA;
          end
        end
        PH_FILL: begin
          emit   = 1'b1;
          res    = sector_res(KIND_FILL, left_q[0], eof ? 8'd0 : b, mrd, hf_q, cyl_q,
                              size_q, mode_q);
          left_d = '0;
          if (fc_inc == cnt_q) begin
            ph_d = PH_HDR; fc_d = '0; seen_d = seen_q + 8'd1;
          end else begin
            ph_d = PH_SREC; fc_d = fc_inc;
          end
        end
        PH_DATA: begin
          emit           = 1'b1;
          res.kind       = KIND_DATA;
          res.value      = eof ? 8'd0 : b;
          res.last_byte  = (left_q <= 14'd1);
          if (left_q <= 14'd1) begin
            left_d = '0;
            if (fc_inc == cnt_q) begin
              ph_d = PH_HDR; fc_d = '0; seen_d = seen_q + 8'd1;
            end else begin
              ph_d = PH_SREC; fc_d = fc_inc;
            end
          end else begin
            left_d = left_q - 14'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= TrackLimitReset;
      ph_q    <= PH_SIG;
      fc_q    <= '0;
      mode_q  <= '0;
      cyl_q   <= '0;
      hf_q    <= '0;
      cnt_q   <= '0;
      size_q  <= '0;
      left_q  <= '0;
      seen_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_data_i;
      ph_q   <= ph_d;
      fc_q   <= fc_d;
      mode_q <= mode_d;
      cyl_q  <= cyl_d;
      hf_q   <= hf_d;
      cnt_q  <= cnt_d;
      size_q <= size_d;
      left_q <= left_d;
      seen_q <= seen_d;
      if (in_ready_o) ov_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && emit) od_q <= res;
  end

endmodule
`default_nettype wire

>>> rtl/imd_map_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IMD sector map store
// Three sector-indexed maps in one memory, one byte lane each; one write and
// one registered read per cycle.
// ----------------------------------------------------------------------------
module imd_map_store #(
  parameter int unsigned MaxSectors = imd_pkg::MaxSectorsDef
) (
  input  wire logic           clk_i,
  input  wire imd_pkg::map_req_t req_i,
  output imd_pkg::map_rd_t    rd_o
);
  import imd_pkg::*;

  localparam int unsigned Aw = (MaxSectors > 1) ? $clog2(MaxSectors) : 1;

  // lanes: [7:0] sector number, [15:8] cylinder, [23:16] head
  logic [23:0] mem [MaxSectors];

  logic         wok, rok, hit;
  logic [Aw-1:0] wa, ra;

  assign wok = 32'(req_i.idx) < MaxSectors;
  assign rok = 32'(req_i.ridx) < MaxSectors;
  assign wa  = Aw'(req_i.idx);
  assign ra  = Aw'(req_i.ridx);
  assign hit = wok && (wa == ra);

  always_ff @(posedge clk_i) begin
    if (wok && req_i.we_s) mem[wa][7:0]   <= req_i.wdata;
    if (wok && req_i.we_c) mem[wa][15:8]  <= req_i.wdata;
    if (wok && req_i.we_h) mem[wa][23:16] <= req_i.wdata;
  end

  // out-of-range entries read as zero; a write to the entry being read is
  // passed straight through
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_o.sec <= !rok ? 8'h00 : (hit && req_i.we_s) ? req_i.wdata : mem[ra][7:0];
      rd_o.cyl <= !rok ? 8'h00 : (hit && req_i.we_c) ? req_i.wdata : mem[ra][15:8];
      rd_o.hd  <= !rok ? 8'h00 : (hit && req_i.we_h) ? req_i.wdata : mem[ra][23:16];
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/imd_deframer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMD deframer checker
// Watches the item, result and register ports of the deframer, predicts the
// result of every accepted item and compares it field by field.
// ----------------------------------------------------------------------------
module imd_deframer_checker
  import imd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic      in_valid_i,
  input  wire logic      in_ready_i,
  input  wire in_item_t  in_data_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_ready_i,
  input  wire out_item_t out_data_i,
  output int             pending_o,
  output int             errors_o
);

  localparam logic [7:0] SigByte [6] = '{8'h49, 8'h4d, 8'h44, 8'h20, 8'h31, 8'h2e};

  out_item_t  expected_q[$];
  int         n_errors;

  logic [7:0] limit;
  phase_e     phase;
  logic [7:0] fc;
  logic [2:0] tmode;
  logic [7:0] tcyl;
  logic [7:0] hflags;
  logic [7:0] scnt;
  logic [2:0] tsize;
  logic [7:0] sec_map [256];
  logic [7:0] cyl_map [256];
  logic [7:0] hd_map  [256];
  logic [15:0] left;
  logic [7:0] seen;

  assign pending_o = expected_q.size();
  assign errors_o  = n_errors;

  function automatic out_item_t plain_result(kind_e k, logic [7:0] val, logic last,
                                             err_e code);
    out_item_t r;
    r            = '0;
    r.kind       = k;
    r.value      = val;
    r.last_byte  = last;
    r.error_code = code;
    return r;
  endfunction

  function automatic out_item_t sector_result(kind_e k, logic del, logic [7:0] val);
    out_item_t r;
    r                = plain_result(k, val, 1'b0, ERR_NONE);
    r.cylinder       = hflags[7] ? cyl_map[fc] : tcyl;
    r.head           = hflags[6] ? hd_map[fc] : {4'h0, hflags[3:0]};
    r.sector_id      = sec_map[fc];
    r.size_code      = tsize;
    r.deleted        = del;
    r.fm_track       = (tmode <= 3'd2);
    return r;
  endfunction

  task automatic raise(err_e code);
    phase = PH_ERR;
    expected_q.push_back(plain_result(KIND_ERROR, 8'h00, 1'b0, code));
  endtask

  task automatic image_done();
    phase = PH_DONE;
    expected_q.push_back(plain_result(KIND_DONE, 8'h00, 1'b0, ERR_NONE));
  endtask

  task automatic next_track();
    seen  = seen + 8'd1;
    phase = PH_HDR;
    fc    = '0;
  endtask

  task automatic end_of_maps();
    logic [31:0] total;
    total = (32'd128 << tsize) * scnt;
    if (total > 32'd32768) begin
      raise(ERR_TOO_LARGE);
    end else begin
      fc = '0;
      if (scnt == 8'd0) next_track();
      else phase = PH_SREC;
    end
  endtask

  task automatic next_sector();
    fc = fc + 8'd1;
    if (fc == scnt) next_track();
    else phase = PH_SREC;
  endtask

  task automatic predict_item(logic [7:0] b, logic eof);
    logic [7:0] h;
    logic       last;
    case (phase)
      PH_SIG: begin
        if (eof || fc >= 8'd6 || b != SigByte[fc[2:0]]) begin
          raise(ERR_NOT_IMD);
        end else begin
          fc = fc + 8'd1;
          if (fc == 8'd6) begin
            phase = PH_CMT_FIRST;
            fc    = '0;
          end
        end
      end
      PH_CMT_FIRST, PH_CMT_NEXT: begin
        if (eof) begin
          if (phase == PH_CMT_FIRST) raise(ERR_NOT_IMD);
          else image_done();
        end else if (b == CommentEnd) begin
          phase = PH_HDR;
          fc    = '0;
          seen  = '0;
        end
      end
      PH_HDR: begin
        if (fc == 8'd0 && seen >= limit) begin
          raise(ERR_TOO_MANY);
        end else if (fc == 8'd0 && seen >= MaxTrackRecordsDef) begin
          // disk full: look for the comment end of the next disk
          if (eof) begin
            image_done();
          end else if (b == CommentEnd) begin
            seen = '0;
          end else begin
            phase = PH_CMT_NEXT;
          end
        end else if (eof) begin
          image_done();
        end else begin
          case (fc)
            8'd0: tmode = (b > 8'd5) ? 3'd7 : b[2:0];
            8'd1: tcyl = b;
            8'd2: hflags = b;
            8'd3: scnt = b;
            default: tsize = (b > 8'd6) ? 3'd7 : b[2:0];
          endcase
          if (fc < 8'd4) begin
            fc = fc + 8'd1;
          end else begin
            fc = '0;
            if (tmode > 3'd5) raise(ERR_MODE);
            else if (hflags[3:0] > 4'd1) raise(ERR_HEAD);
            else if (tsize > 3'd6) raise(ERR_SIZE);
            else if (scnt == 8'd0) end_of_maps();
            else phase = PH_SMAP;
          end
        end
      end
      PH_SMAP, PH_CMAP, PH_HMAP: begin
        if (eof) begin
          raise(ERR_TRUNCATED);
        end else begin
          if (phase == PH_SMAP) sec_map[fc] = b;
          else if (phase == PH_CMAP) cyl_map[fc] = b;
          else hd_map[fc] = b;
          fc = fc + 8'd1;
          if (fc == scnt) begin
            fc = '0;
            if (phase == PH_SMAP && hflags[7]) phase = PH_CMAP;
            else if (phase != PH_HMAP && hflags[6]) phase = PH_HMAP;
            else end_of_maps();
          end
        end
      end
      PH_SREC: begin
        if (eof) begin
          raise(ERR_TRUNCATED);
        end else if (b == 8'd0) begin
          expected_q.push_back(sector_result(KIND_FILL, 1'b0, 8'h00));
          next_sector();
        end else begin
          h = b - 8'd1;
          if (h[0]) begin
            left  = {15'd0, h[1]};
            phase = PH_FILL;
          end else begin
            expected_q.push_back(sector_result(KIND_HEADER, h[1], 8'h00));
            left  = 16'd128 << tsize;
            phase = PH_DATA;
          end
        end
      end
      PH_FILL: begin
        expected_q.push_back(sector_result(KIND_FILL, left[0], eof ? 8'h00 : b));
        left = '0;
        next_sector();
      end
      PH_DATA: begin
        last = (left <= 16'd1);
        expected_q.push_back(plain_result(KIND_DATA, eof ? 8'h00 : b, last, ERR_NONE));
        if (last) begin
          left = '0;
          next_sector();
        end else begin
          left = (left - 16'd1) & 16'h3fff;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0d got %0d", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      limit  = TrackLimitReset;
      phase  = PH_SIG;
      fc     = '0;
      tmode  = '0;
      tcyl   = '0;
      hflags = '0;
      scnt   = '0;
      tsize  = '0;
      left   = '0;
      seen   = '0;
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result kind %0d", out_data_i.kind);
          n_errors++;
        end else begin
          e = expected_q.pop_front();
          check_field("kind", e.kind, out_data_i.kind);
          check_field("cylinder", e.cylinder, out_data_i.cylinder);
          check_field("head", e.head, out_data_i.head);
          check_field("sector_id", e.sector_id, out_data_i.sector_id);
          check_field("size_code", e.size_code, out_data_i.size_code);
          check_field("deleted", e.deleted, out_data_i.deleted);
          check_field("fm_track", e.fm_track, out_data_i.fm_track);
          check_field("value", e.value, out_data_i.value);
          check_field("last_byte", e.last_byte, out_data_i.last_byte);
          check_field("error_code", e.error_code, out_data_i.error_code);
        end
      end
      if (cfg_we_i) limit = cfg_data_i;
      if (in_valid_i && in_ready_i) predict_item(in_data_i.data_byte, in_data_i.stream_end);
    end
  end

  initial n_errors = 0;

endmodule

>>> tb/sv/tb_imd_disk_image_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMD disk image deframer testbench
// Feeds a long IMD image of directed and random tracks through the deframer,
// crossing the per-disk track cap, and ends it on a randomly chosen error or
// end-of-file case; a checker compares every result with its prediction.
// ----------------------------------------------------------------------------
module tb_imd_disk_image_deframer;
  import imd_pkg::*;

  localparam logic [7:0] SigByte [6] = '{8'h49, 8'h4d, 8'h44, 8'h20, 8'h31, 8'h2e};

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [7:0] cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;
  int        pending;
  int        n_errors;

  int burst_left = 0;
  int disk_tracks = 0;
  bit limit_moved = 0;

  always #6 clk_i = ~clk_i;

  imd_disk_image_deframer uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  imd_deframer_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_ready_i(in_ready_o),
    .in_data_i, .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .pending_o(pending), .errors_o(n_errors)
  );

  task automatic send_item(logic [7:0] b, logic eof);
    bit took;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: b, stream_end: eof};
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(b, 1'b0);
  endtask

  // data byte, now and then replaced by an end of file counted as zero
  task automatic send_payload();
    if ($urandom_range(0, 59) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
    else send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (pending == 0) break;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [7:0] v);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_type(int plain_pct, bit plain_ok);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'd0;
    if (plain_ok && r < 15 + plain_pct) return 8'(2 * $urandom_range(0, 127) + 1);
    return 8'(2 * $urandom_range(1, 127));
  endfunction

  task automatic send_track(logic [7:0] mode, logic [7:0] cyl, logic [7:0] hf,
                            logic [7:0] cnt, logic [7:0] sz, logic [7:0] types[$],
                            int plain_pct);
    logic [7:0] t;
    send_byte(mode);
    send_byte(cyl);
    send_byte(hf);
    send_byte(cnt);
    send_byte(sz);
    repeat (cnt) send_byte(8'($urandom_range(0, 255)));
    if (hf[7]) repeat (cnt) send_byte(8'($urandom_range(0, 255)));
    if (hf[6]) repeat (cnt) send_byte(8'($urandom_range(0, 255)));
    for (int s = 0; s < cnt; s++) begin
      t = (s < types.size()) ? types[s] : pick_type(plain_pct, sz == 8'd0);
      send_byte(t);
      if (t != 8'd0) begin
        if (t[0]) repeat (128 << sz) send_payload();
        else send_payload();
      end
    end
    disk_tracks++;
  endtask

  task automatic random_track(int plain_pct);
    logic [7:0] hf;
    logic [7:0] none[$];
    hf = {4'($urandom_range(0, 15)), 3'b000, 1'($urandom_range(0, 1))};
    send_track(8'($urandom_range(0, 5)), 8'($urandom_range(0, 255)), hf,
               8'($urandom_range(0, 1)), 8'($urandom_range(0, 6)), none, plain_pct);
  endtask

  // at the cap a new disk starts after the next comment end
  task automatic start_next_disk();
    logic [7:0] b;
    repeat ($urandom_range(0, 3)) begin
      do b = 8'($urandom_range(0, 255)); while (b == CommentEnd);
      send_byte(b);
    end
    send_byte(CommentEnd);
    disk_tracks = 0;
  endtask

  task automatic finish_image();
    logic [7:0] none[$];
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: send_item(8'($urandom_range(0, 255)), 1'b1);
      1: begin
        send_byte(8'd1);
        send_byte(8'd3);
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      2: send_track(8'($urandom_range(6, 255)), 0, 0, 1, 0, none, 0);
      3: send_track(0, 0, 8'($urandom_range(2, 15)), 1, 0, none, 0);
      4: send_track(0, 0, 0, 1, 8'($urandom_range(7, 255)), none, 0);
      5: begin
        // 5 x 8192 bytes is over the track size limit
        send_track(1, 2, 8'h00, 5, 6, none, 0);
      end
      6: begin
        send_byte(0); send_byte(0); send_byte(8'hc0); send_byte(3); send_byte(0);
        send_byte(8'($urandom_range(0, 255)));
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      7: begin
        send_byte(0); send_byte(0); send_byte(0); send_byte(1); send_byte(0);
        send_byte(8'($urandom_range(0, 255)));
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      8: begin
        write_limit(8'd1);
        send_byte(0);
      end
      default: begin
        while (disk_tracks < MaxTrackRecordsDef) begin
          send_track(0, 0, 0, 0, 0, none, 0);
        end
        if ($urandom_range(0, 1)) begin
          do b = 8'($urandom_range(0, 255)); while (b == CommentEnd);
          send_byte(b);
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
    // everything after the end is ignored
    repeat (10) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // receiver: random stalls at a changing stall rate, with one long hold-off
  initial begin
    int cyc;
    int stall_pct;
    cyc = 0;
    stall_pct = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc == 3000) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        cyc += 400;
      end
      if (cyc % 250 == 0) stall_pct = 30 * $urandom_range(0, 3);
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("tb_imd_disk_image_deframer failed");
    $finish;
  end

  initial begin
    logic [7:0] b;
    logic [7:0] types[$];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // signature, comment, then directed tracks at the reset track limit
    for (int i = 0; i < 6; i++) send_byte(SigByte[i]);
    repeat (4) begin
      do b = 8'($urandom_range(0, 255)); while (b == CommentEnd);
      send_byte(b);
    end
    send_byte(CommentEnd);
    types = {};
    send_track(0, 0, 8'h00, 0, 0, types, 0);
    types = {8'd0, 8'd1, 8'd2, 8'd3, 8'd4};
    send_track(5, 255, 8'hc1, 5, 0, types, 0);
    types = {8'd2, 8'd8};
    send_track(2, 7, 8'h80, 2, 6, types, 0);
    types = {8'd5, 8'd255};
    send_track(3, 40, 8'h41, 16, 0, types, 0);
    types = {8'd6, 8'd254};
    send_track(4, 128, 8'h31, 2, 1, types, 0);

    write_limit(8'd255);
    for (int k = 0; k < 202; k++) begin
      if (disk_tracks == MaxTrackRecordsDef) begin
        if (!limit_moved) begin
          write_limit(8'($urandom_range(205, 254)));
          limit_moved = 1;
        end
        start_next_disk();
      end
      random_track(3);
    end
    finish_image();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (n_errors == 0 && pending == 0) begin
      $display("tb_imd_disk_image_deframer passed");
    end else begin
      $display("tb_imd_disk_image_deframer failed");
    end
    $finish;
  end

endmodule

>>> imd_disk_image_deframer.f
rtl/imd_pkg.sv
rtl/imd_map_store.sv
rtl/imd_disk_image_deframer.sv
tb/sv/imd_deframer_checker.sv
tb/sv/tb_imd_disk_image_deframer.sv
